@@ rtl/lph_pkg.sv @@
// Shared types and constants for the linear-probe hash lookup block.
package lph_pkg;

	localparam int unsigned KEY_W       = 64;
	localparam int unsigned SLOT_W      = 10;
	localparam int unsigned CFG_W       = 11;
	localparam int unsigned HASH_W      = 32;
	localparam int unsigned DIV_RADIX_W = 4;
	localparam int unsigned DIV_STEPS   = HASH_W / DIV_RADIX_W;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_ABSENT   = 2'd1,
		ST_INSERTED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] search_key;
		logic             create;
	} request_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIVIDE,
		S_READ,
		S_CHECK
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		logic    home;
		logic    advance;
		logic    write;
		logic    clr_en;
		logic    res_load;
		status_t res_status;
	} lph_cmd_t;

	typedef struct packed {
		logic div_done;
		logic key_zero;
		logic create;
		logic empty;
		logic hit;
		logic last;
		logic clr_last;
	} lph_stat_t;

endpackage

@@ rtl/lph_divider.sv @@
// Iterative remainder unit: 32-bit hash modulo the slot count, four bits per cycle.
module lph_divider import lph_pkg::*; #(
	parameter int unsigned CW = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [CW-1:0]     divisor,
	output logic              done,
	output logic [CW-1:0]     remainder
);

	localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [HASH_W-1:0] dvd_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     div_q;
	logic [HASH_W-1:0] dvd_nxt;
	logic [CW-1:0]     rem_nxt;

	always_comb begin
		logic [CW:0] trial;
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_RADIX_W; i++) begin
			trial = {rem_nxt, dvd_nxt[HASH_W-1]};
			dvd_nxt = {dvd_nxt[HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_nxt = trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/lph_datapath.sv @@
// Datapath: key store, probe index, slot-count register, remainder unit and result register.
module lph_datapath import lph_pkg::*; #(
	parameter int unsigned SLOTS    = 1024,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lph_cmd_t         cmd,
	output lph_stat_t        stat,
	input  request_t         req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             done,
	output result_t          result
);

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned NW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [NW-1:0] SLOTS_N = NW'(SLOTS);

	logic [CFG_W-1:0]    table_slots_q;
	logic [KEY_BITS-1:0] key_q;
	logic                create_q;
	logic [CW-1:0]       n_q;
	logic [IW-1:0]       idx_q;
	logic [CW-1:0]       visited_q;
	logic [IW-1:0]       clr_q;
	logic [KEY_BITS-1:0] rd_q;
	logic                done_q;
	result_t             res_q;
	logic [KEY_BITS-1:0] mem [SLOTS];

	logic [NW-1:0] cfg_ext;
	logic [CW-1:0] eff_slots;
	logic [CW-1:0] rem;
	logic [CW-1:0] idx_inc;

	// Clamp the slot count to 1..SLOTS.
	always_comb begin
		cfg_ext = NW'(table_slots_q);
		priority if (table_slots_q == '0) begin
			eff_slots = CW'(1);
		end else if (cfg_ext > SLOTS_N) begin
			eff_slots = CW'(SLOTS);
		end else begin
			eff_slots = CW'(cfg_ext);
		end
	end

	lph_divider #(.CW(CW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (req.search_key[HASH_W-1:0]),
		.divisor   (eff_slots),
		.done      (stat.div_done),
		.remainder (rem)
	);

	assign idx_inc = CW'(idx_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_slots_q <= CFG_W'(1024);
			clr_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_slots_q <= cfg_data;
			end
			if (cmd.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= cmd.res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= req.search_key[KEY_BITS-1:0];
			create_q <= req.create;
			n_q      <= eff_slots;
		end
		if (cmd.home) begin
			idx_q     <= IW'(rem);
			visited_q <= '0;
		end else if (cmd.advance) begin
			idx_q     <= (idx_inc == n_q) ? '0 : IW'(idx_inc);
			visited_q <= visited_q + 1'b1;
		end
		if (cmd.res_load) begin
			res_q.status <= cmd.res_status;
			if (cmd.res_status == ST_FOUND || cmd.res_status == ST_INSERTED) begin
				res_q.slot <= SLOT_W'(idx_q);
			end else begin
				res_q.slot <= '0;
			end
		end
	end

	// Key store: one write port shared by the clearing sweep and inserts.
	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem[clr_q] <= '0;
		end else if (cmd.write) begin
			mem[idx_q] <= key_q;
		end
		rd_q <= mem[idx_q];
	end

	assign stat.key_zero = (key_q == '0);
	assign stat.create   = create_q;
	assign stat.empty    = (rd_q == '0);
	assign stat.hit      = (rd_q == key_q);
	assign stat.last     = (visited_q == n_q - 1'b1);
	assign stat.clr_last = (clr_q == IW'(SLOTS - 1));

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/lph_ctrl.sv @@
// Controller state machine: clearing sweep, divide, probe read and compare.
module lph_ctrl import lph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lph_stat_t stat,
	output lph_cmd_t  cmd,
	output logic      busy
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nxt = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (stat.div_done) state_nxt = stat.key_zero ? S_IDLE : S_READ;
			end
			S_READ: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (stat.empty || stat.hit || stat.last) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_READ;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.res_status = ST_ABSENT;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			S_IDLE: begin
				cmd.load      = start;
				cmd.div_start = start;
			end
			S_DIVIDE: begin
				if (stat.div_done) begin
					cmd.home     = !stat.key_zero;
					cmd.res_load = stat.key_zero;
				end
			end
			S_READ: begin
			end
			S_CHECK: begin
				// Empty slot ends the walk before a key compare; full walk last.
				priority if (stat.empty) begin
					cmd.res_load   = 1'b1;
					cmd.write      = stat.create;
					cmd.res_status = stat.create ? ST_INSERTED : ST_ABSENT;
				end else if (stat.hit) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_FOUND;
				end else if (stat.last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = stat.create ? ST_FULL : ST_ABSENT;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ rtl/linear_probe_hash_lookup.sv @@
// Top level of the linear-probe hash lookup block.
//
// Usage: pulse start with a request (search_key, create) while busy is low;
// the transaction is taken at that edge and busy rises on the next cycle.
// Each request yields exactly one result, shown on result for one cycle
// with done high; the receiver cannot stall, so it must capture it then.
// The home slot is the low 32 key bits modulo the slot count, computed by
// a radix-16 remainder unit. Each probe then takes a key-store read and a
// compare, because the store read is registered. A zero key is answered
// as absent without a probe once the remainder is done. A new request may
// be started in the cycle done is high.
// The slot-count register is written on cfg_valid && cfg_ready; cfg_ready
// is high whenever the block is idle and start is low, and the count is
// sampled per request.
// After reset the key store is swept to zero, one slot per cycle, over all
// SLOTS slots; busy stays high during the sweep and the register cannot be
// written until it ends.
module linear_probe_hash_lookup import lph_pkg::*; #(
	parameter int unsigned SLOTS    = 1024,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         req,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             done,
	output result_t          result
);

	lph_cmd_t  cmd;
	lph_stat_t stat;

	lph_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lph_datapath #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	// Hold off register writes while busy and while a request is being taken.
	assign cfg_ready = !busy && !start;

endmodule

@@ rtl/lph_checker.sv @@
// Port-level checker for the linear-probe hash lookup block, with its bind.
module lph_checker import lph_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// Results never arrive back to back: done always drops after a result.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while block still busy");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_ABSENT || result.status == ST_FULL)
			|-> result.slot == '0)
		else $error("nonzero slot with absent or full status");

endmodule

bind linear_probe_hash_lookup lph_checker u_lph_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
